@@ rtl/core/tdpb_pkg.sv @@
// types, step codes and control program of the tail drop packet buffer
package tdpb_pkg;

  typedef struct packed {
    logic [31:0] arrive_at;
    logic [15:0] work_len;
  } in_item_t;

  typedef struct packed {
    logic        dropped;
    logic [31:0] serve_at;
  } out_item_t;

  typedef logic [2:0] step_t;

  localparam step_t S_WAIT   = 3'd0;
  localparam step_t S_RETIRE = 3'd1;
  localparam step_t S_SETTLE = 3'd2;
  localparam step_t S_DECIDE = 3'd3;
  localparam step_t S_COMMIT = 3'd4;
  localparam step_t S_EMIT   = 3'd5;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN,
    C_RETIRE,
    C_FULL,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t on_true;
    step_t on_false;
    logic  latch_in;
    logic  retire;
    logic  decide;
    logic  commit;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic retire_ok;
    logic full;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic latch_in;
    logic retire;
    logic decide;
    logic commit;
    logic emit;
    logic hit;
  } ctl_t;

  function automatic uword_t program_rom(input step_t step);
    uword_t w;
    w = '{cond: C_IN, on_true: S_RETIRE, on_false: S_WAIT, latch_in: 1'b1,
          retire: 1'b0, decide: 1'b0, commit: 1'b0, emit: 1'b0};
    unique case (step)
      S_WAIT: begin
        w = '{cond: C_IN, on_true: S_RETIRE, on_false: S_WAIT, latch_in: 1'b1,
              retire: 1'b0, decide: 1'b0, commit: 1'b0, emit: 1'b0};
      end
      S_RETIRE: begin
        w = '{cond: C_RETIRE, on_true: S_SETTLE, on_false: S_DECIDE, latch_in: 1'b0,
              retire: 1'b1, decide: 1'b0, commit: 1'b0, emit: 1'b0};
      end
      S_SETTLE: begin
        w = '{cond: C_ALWAYS, on_true: S_RETIRE, on_false: S_RETIRE, latch_in: 1'b0,
              retire: 1'b0, decide: 1'b0, commit: 1'b0, emit: 1'b0};
      end
      S_DECIDE: begin
        w = '{cond: C_FULL, on_true: S_EMIT, on_false: S_COMMIT, latch_in: 1'b0,
              retire: 1'b0, decide: 1'b1, commit: 1'b0, emit: 1'b0};
      end
      S_COMMIT: begin
        w = '{cond: C_ALWAYS, on_true: S_EMIT, on_false: S_EMIT, latch_in: 1'b0,
              retire: 1'b0, decide: 1'b0, commit: 1'b1, emit: 1'b0};
      end
      S_EMIT: begin
        w = '{cond: C_OUT_FREE, on_true: S_WAIT, on_false: S_EMIT, latch_in: 1'b0,
              retire: 1'b0, decide: 1'b0, commit: 1'b0, emit: 1'b1};
      end
      default: begin
        w = '{cond: C_ALWAYS, on_true: S_WAIT, on_false: S_WAIT, latch_in: 1'b0,
              retire: 1'b0, decide: 1'b0, commit: 1'b0, emit: 1'b0};
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/tdpb_seq.sv @@
// step counter and control program decode
module tdpb_seq (
  input  logic            clk,
  input  logic            rst,
  input  tdpb_pkg::flags_t flags,
  output tdpb_pkg::ctl_t   ctl
);
  import tdpb_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   hit;

  assign word = program_rom(pc);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:   hit = 1'b1;
      C_IN:       hit = flags.in_valid;
      C_RETIRE:   hit = flags.retire_ok;
      C_FULL:     hit = flags.full;
      C_OUT_FREE: hit = flags.out_free;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = hit ? word.on_true : word.on_false;
  end

  always_comb begin
    ctl.latch_in = word.latch_in;
    ctl.retire   = word.retire;
    ctl.decide   = word.decide;
    ctl.commit   = word.commit;
    ctl.emit     = word.emit;
    ctl.hit      = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/core/tail_drop_packet_buffer_core.sv @@
// top level of the tail drop packet buffer: finish ring, datapath and sequencer
//
//  port group | direction | handshake          | content
//  in_*       | in        | in_valid / in_stall   | arrive_at, work_len
//  out_*      | out       | out_valid / out_stall | dropped, serve_at
//  cfg_*      | in        | cfg_valid / cfg_ready | buffer_size
//
// one packet at a time: after acceptance the program steps through retire, decide, commit
// and emit, with commit skipped when dropped and a settle step after each finish time
// retired from the ring, these steps placed around the registered ring read port
// the next packet is taken while the last result still waits in the output register
// a stalled output holds the final step until the output register frees
// reset empties the ring at once through the count, with no clearing pass
module tail_drop_packet_buffer_core #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tdpb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tdpb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import tdpb_pkg::*;

  localparam int IW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW    = $clog2(MAX_DEPTH + 1);
  localparam int SW    = (CW > 7) ? CW : 7;
  localparam int TW    = CW + 1;

  logic [31:0]   ring [MAX_DEPTH];
  logic [31:0]   head_finish;
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [IW-1:0] tail;
  logic [TW-1:0] tail_sum;
  logic [CW-1:0] count;
  logic [31:0]   last_finish;
  logic [6:0]    buffer_size;
  logic [SW-1:0] eff_size;
  logic [31:0]   arrival;
  logic [15:0]   proc;
  logic [31:0]   start;
  logic          drop;
  logic [32:0]   fin_sum;
  logic [31:0]   fin;
  out_item_t     result;
  flags_t        flags;
  ctl_t          ctl;

  tdpb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  assign in_stall  = !ctl.latch_in;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (buffer_size == 7'd0) begin
      eff_size = SW'(1);
    end else if (SW'(buffer_size) > SW'(MAX_DEPTH)) begin
      eff_size = SW'(MAX_DEPTH);
    end else begin
      eff_size = SW'(buffer_size);
    end
  end

  always_comb begin
    head_next = (head == IW'(MAX_DEPTH - 1)) ? '0 : head + IW'(1);
    tail_sum  = TW'(head) + TW'(count);
    tail      = (tail_sum >= TW'(MAX_DEPTH)) ? IW'(tail_sum - TW'(MAX_DEPTH))
                                             : IW'(tail_sum);
    fin_sum   = {1'b0, start} + 33'(proc);
    fin       = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
  end

  always_comb begin
    flags.in_valid  = in_valid;
    flags.retire_ok = (count != '0) && (head_finish <= arrival);
    flags.full      = SW'(count) >= eff_size;
    flags.out_free  = !out_valid || !out_stall;
  end

  // ring port: read of the head entry every cycle, write of the tail on commit
  always_ff @(posedge clk) begin
    head_finish <= ring[head];
    if (ctl.commit) begin
      ring[tail] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in && ctl.hit) begin
      arrival <= in_data.arrive_at;
      proc    <= in_data.work_len;
    end
    if (ctl.decide) begin
      drop  <= ctl.hit;
      start <= (count != '0 && last_finish > arrival) ? last_finish : arrival;
    end
    if (ctl.emit && ctl.hit) begin
      out_data <= result;
    end
  end

  always_comb begin
    result.dropped  = drop;
    result.serve_at = drop ? 32'd0 : start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      last_finish <= '0;
      buffer_size <= 7'd64;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        buffer_size <= cfg_data;
      end
      if (ctl.retire && ctl.hit) begin
        head  <= head_next;
        count <= count - CW'(1);
      end else if (ctl.commit) begin
        count       <= count + CW'(1);
        last_finish <= fin;
      end
      if (ctl.emit && ctl.hit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tdpb_checker.sv @@
// port checker of the tail drop packet buffer and its bind
module tdpb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tdpb_pkg::out_item_t out_data
);
  import tdpb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dropped |-> out_data.serve_at == 32'd0)
    else $error("dropped request with nonzero start time");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind tail_drop_packet_buffer_core tdpb_checker u_tdpb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tb_tail_drop_packet_buffer_core.sv @@
// self-checking testbench of the tail drop packet buffer core
module tb_tail_drop_packet_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpb_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int EARLY_ROWS    = 17;
  localparam int PLAN_LEN      = 24;
  localparam int RANDOM_TARGET = 1330;
  localparam int CALM_TAIL     = 150;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;

  typedef enum logic {ROW_SIZE, ROW_PKT} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [6:0]  size;
    logic [31:0] arrival;
    logic [15:0] proc;
    logic        known;
    logic        drop;
    logic [31:0] start;
  } row_t;

  // early rows run right after reset, the top-of-range rows close the run
  row_t plan_rows [PLAN_LEN] = '{
    '{ROW_PKT,  7'd0,   32'd0,          16'd0,      1'b1, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd0,          16'hFFFF,   1'b1, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd10,         16'd5,      1'b0, 1'b0, 32'd0},
    '{ROW_SIZE, 7'd1,   32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd20,         16'd1,      1'b1, 1'b1, 32'd0},
    '{ROW_PKT,  7'd0,   32'd65540,      16'd3,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd65541,      16'd0,      1'b1, 1'b1, 32'd0},
    '{ROW_SIZE, 7'd0,   32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd65542,      16'd0,      1'b1, 1'b1, 32'd0},
    '{ROW_PKT,  7'd0,   32'd100000,     16'd7,      1'b1, 1'b0, 32'd100000},
    '{ROW_PKT,  7'd0,   32'd50,         16'd1,      1'b1, 1'b1, 32'd0},
    '{ROW_SIZE, 7'd127, 32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd100001,     16'd1,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd100001,     16'd2,      1'b0, 1'b0, 32'd0},
    '{ROW_SIZE, 7'd2,   32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'd100002,     16'd0,      1'b1, 1'b1, 32'd0},
    '{ROW_SIZE, 7'd64,  32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_SIZE, 7'd64,  32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'hFFFF_FFF0,  16'hFFFF,   1'b1, 1'b0, 32'hFFFF_FFF0},
    '{ROW_PKT,  7'd0,   32'hFFFF_FFF0,  16'd1,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'hFFFF_FFFF,  16'd0,      1'b1, 1'b0, 32'hFFFF_FFFF},
    '{ROW_PKT,  7'd0,   32'hFFFF_FFFF,  16'hFFFF,   1'b1, 1'b0, 32'hFFFF_FFFF},
    '{ROW_SIZE, 7'd1,   32'd0,          16'd0,      1'b0, 1'b0, 32'd0},
    '{ROW_PKT,  7'd0,   32'hFFFF_FFFE,  16'd2,      1'b1, 1'b1, 32'd0}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [6:0] cfg_data;

  logic [31:0] fin_ring [RING_DEPTH];
  int          ring_head;
  int          ring_count;
  logic [31:0] newest_finish;
  logic [6:0]  size_setting;

  out_item_t   due_verdicts [$];
  int          packets_sent;
  int          results_seen;
  int          drops_seen;
  int          mismatches;
  int          stall_pct;
  bit          calm;
  bit          hold_wanted;
  bit          long_hold_done;
  int unsigned arrival_now;

  tail_drop_packet_buffer_core #(
    .MAX_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t schedule_packet(input in_item_t pkt);
    out_item_t   verdict;
    logic [32:0] fin;
    int          cap;
    cap = (size_setting == 7'd0) ? 1 :
          (size_setting > RING_DEPTH) ? RING_DEPTH : int'(size_setting);
    while (ring_count > 0 && fin_ring[ring_head] <= pkt.arrive_at) begin
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_count--;
    end
    verdict.dropped = 1'b0;
    verdict.serve_at = pkt.arrive_at;
    if (ring_count >= cap) begin
      verdict.dropped = 1'b1;
      verdict.serve_at = 32'd0;
    end else begin
      if (ring_count > 0 && newest_finish > verdict.serve_at) begin
        verdict.serve_at = newest_finish;
      end
      fin = {1'b0, verdict.serve_at} + {17'd0, pkt.work_len};
      newest_finish = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
      fin_ring[(ring_head + ring_count) % RING_DEPTH] = newest_finish;
      ring_count++;
    end
    return verdict;
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back request
  task automatic offer_packet(input in_item_t pkt, input logic known, input out_item_t typed);
    out_item_t verdict;
    in_valid <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (in_stall);
    verdict = schedule_packet(pkt);
    due_verdicts.insert(due_verdicts.size(), known ? typed : verdict);
    packets_sent++;
    @(negedge clk);
  endtask

  task automatic sender_pause(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_size(input logic [6:0] value);
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    size_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_rows(input int first, input int last);
    row_t      row;
    in_item_t  pkt;
    out_item_t typed;
    for (int i = first; i <= last; i++) begin
      row = plan_rows[i];
      if (row.kind == ROW_SIZE) begin
        write_size(row.size);
      end else begin
        pkt.arrive_at = row.arrival;
        pkt.work_len = row.proc;
        typed.dropped = row.drop;
        typed.serve_at = row.start;
        offer_packet(pkt, row.known, typed);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.dropped) drops_seen++;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got dropped=%0b serve_at=%0h",
                 $time, out_data.dropped, out_data.serve_at);
      end else begin
        want = due_verdicts.pop_front();
        if (out_data.dropped !== want.dropped) begin
          mismatches++;
          $display("%0t: dropped mismatch, expected %0b, got %0b",
                   $time, want.dropped, out_data.dropped);
        end
        if (out_data.serve_at !== want.serve_at) begin
          mismatches++;
          $display("%0t: serve_at mismatch, expected %0h, got %0h",
                   $time, want.serve_at, out_data.serve_at);
        end
      end
    end
  end

  initial begin : out_side
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      // long hold so the core backs up and stalls its input
      if (!long_hold_done && hold_wanted) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int       span;
    int       gap_pct;
    bit       busy_mode;
    in_item_t pkt;
    logic [6:0] sz;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    ring_head = 0;
    ring_count = 0;
    newest_finish = '0;
    size_setting = 7'd64;
    packets_sent = 0;
    results_seen = 0;
    drops_seen = 0;
    mismatches = 0;
    stall_pct = 0;
    calm = 1'b0;
    hold_wanted = 1'b0;
    long_hold_done = 1'b0;
    arrival_now = 100002;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    run_rows(0, EARLY_ROWS - 1);

    while (packets_sent < RANDOM_TARGET) begin
      calm = (RANDOM_TARGET - packets_sent) <= CALM_TAIL;
      case ($urandom_range(0, 7))
        0: sz = 7'd1;
        1: sz = 7'd2;
        2: sz = 7'd64;
        3: sz = 7'd0;
        4: sz = 7'($urandom_range(65, 127));
        default: sz = 7'($urandom_range(1, 64));
      endcase
      write_size(sz);
      span = calm ? RANDOM_TARGET - packets_sent : $urandom_range(20, 100);
      busy_mode = $urandom_range(0, 1);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      stall_pct = calm ? 0 : gap_pct;
      for (int k = 0; k < span; k++) begin
        // ask for the long hold with enough of the span left to fill the core
        if (!hold_wanted && packets_sent >= HOLD_AFTER && span - k > 8) begin
          hold_wanted = 1'b1;
        end
        if (!calm && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
          sender_pause($urandom_range(1, 10));
        end
        if ($urandom_range(15) == 0) begin
          // out-of-order arrival with any processing time
          pkt.arrive_at = $urandom_range(arrival_now);
          pkt.work_len = 16'($urandom);
        end else begin
          arrival_now += busy_mode ? $urandom_range(0, 60) : $urandom_range(0, 4000);
          pkt.arrive_at = arrival_now;
          if ($urandom_range(15) == 0) pkt.work_len = 16'($urandom);
          else if (busy_mode) pkt.work_len = 16'($urandom_range(200, 3000));
          else pkt.work_len = 16'($urandom_range(0, 3000));
        end
        offer_packet(pkt, 1'b0, '0);
      end
    end

    calm = 1'b1;
    stall_pct = 0;
    run_rows(EARLY_ROWS, PLAN_LEN - 1);
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d packets offered and %0d results checked, %0d of them tail drops,",
             packets_sent, results_seen, drops_seen);
    $display("buffer sizes 0 to 127, late and saturated times, random stalls on both sides");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
